/* design/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg: shared types and constants
// Field widths, table entry layout, sequencer states and register indexes for
// the channel interval statistics unit.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned TIME_W     = 63;
  localparam int unsigned COUNT_W    = 48;
  localparam int unsigned RATE_W     = 64;
  localparam int unsigned TOTAL_W    = 56;
  localparam int unsigned TPS_W      = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 296;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - COUNT_W - 2 * TIME_W - RATE_W - TOTAL_W;
  localparam int unsigned IN_PAD_W   = IN_DATA_W - CHAN_W - TIME_W;

  localparam int unsigned REG_IDX_W  = 1;
  localparam int unsigned ADDR_W     = REG_IDX_W + 2;
  localparam int unsigned PDATA_W    = 32;

  // scaled product is (count-1)*tps*2^16, 96 bits; upper 32 bits settle overflow
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned FRAC_W     = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [TPS_W-1:0]   TPS_RESET = 32'd1000000000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TPS = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  first_time;
    logic [TIME_W-1:0]  last_time;
    logic [TIME_W-1:0]  min_gap;
    logic [TIME_W-1:0]  max_gap;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_MIN,
    S_MAX,
    S_SPAN,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_OVF,
    S_DIV,
    S_OUT
  } state_e;

endpackage

/* design/channel_interval_statistics_unit.sv */
// ----------------------------------------------------------------------------
// channel_interval_statistics_unit: per-channel sample arrival statistics
//
//   channel   dir  payload                                            handshake
//   s_axis    in   channel, timestamp                                 tvalid/tready
//   m_axis    out  sample_count, shortest_gap, longest_gap, rate_q16,  tvalid/tready
//                  total_samples
//   apb       in   ticks_per_second at byte address 0                 psel/penable
//
// An in-range sample goes through table update, compares and multiply, then
// the restoring divider (one quotient bit a cycle through the shared
// subtractor) when a rate is due; the divide is skipped with no span to
// divide by or a saturated rate. An out-of-range channel goes straight to
// output. Reset clears the count and gap tables at once; no sweep is needed.
// The result waits in an output register; the next sample is taken meanwhile,
// and the sequencer stalls at its end only while that register is still full.
// ----------------------------------------------------------------------------
module channel_interval_statistics_unit #(
  parameter int unsigned CHANNEL_COUNT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [3:0] channel, [66:4] timestamp
  input  logic [cis_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [47:0] sample_count, [110:48] shortest_gap, [173:111] longest_gap,
  // [237:174] rate_q16, [293:238] total_samples
  output logic [cis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cis_pkg::ADDR_W-1:0]     paddr,
  input  logic [cis_pkg::PDATA_W-1:0]    pwdata,
  output logic [cis_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import cis_pkg::*;

  localparam int unsigned ChanSpan   = 1 << CHAN_W;
  localparam int unsigned TableDepth = (CHANNEL_COUNT < ChanSpan) ? CHANNEL_COUNT : ChanSpan;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [TIME_W-1:0]  tstamp;
    logic               in_range;
    logic               first;
    logic               back;
    logic [COUNT_W-1:0] n;
    logic [TIME_W-1:0]  gap;
    logic [TIME_W-1:0]  min_gap;
    logic [TIME_W-1:0]  max_gap;
    logic [TIME_W-1:0]  span;
    logic [WORD_W-1:0]  prod_lo;
    logic [COUNT_W-1:0] prod_hi;
    logic [WORD_W-1:0]  rem;
    logic [WORD_W-1:0]  quo;
    logic [STEP_W-1:0]  step;
    logic [RATE_W-1:0]  rate;
  } dp_t;

  state_e               state_q, state_d;
  dp_t                  dp_q, dp_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [TPS_W-1:0]     tps_q, tps_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [CHAN_W-1:0]    s_chan;
  logic [TIME_W-1:0]    s_time;
  logic                 s_in_range;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 cfg_wr;

  logic                 rd_en;
  entry_t               rd_entry;
  logic                 wr_en;
  entry_t               wr_entry;

  logic [WORD_W-1:0]    alu_a, alu_b, alu_diff, mul_prod;
  logic                 alu_borrow, alu_zero;
  logic [HALF_W-1:0]    mul_a;

  logic                 cnt_sat;
  logic                 gap_ok;
  logic                 n_multi;
  logic [COUNT_W-1:0]   n_minus1;
  logic [COUNT_W-1:0]   acc_top;
  logic [WORD_W-1:0]    rem_sh;
  logic [TIME_W-1:0]    min_out;

  assign s_chan     = s_axis_tdata[CHAN_W-1:0];
  assign s_time     = s_axis_tdata[CHAN_W +: TIME_W];
  assign s_in_range = (32'(s_chan) < CHANNEL_COUNT);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;

  assign cnt_sat  = (rd_entry.count == COUNT_MAX);
  assign gap_ok   = !dp_q.first && !dp_q.back;
  assign n_multi  = (dp_q.n[COUNT_W-1:1] != '0);
  assign n_minus1 = dp_q.n - COUNT_W'(1);
  assign acc_top  = {16'b0, dp_q.prod_lo[WORD_W-1:HALF_W]} + dp_q.prod_hi;
  assign rem_sh   = {dp_q.rem[WORD_W-2:0], dp_q.quo[WORD_W-1]};
  assign min_out  = n_multi ? dp_q.min_gap : '0;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    tps_d  = tps_q;
    prdata = '0;
    unique case (paddr[ADDR_W-1:2])
      REG_TPS: begin
        prdata = tps_q;
        if (cfg_wr) begin
          tps_d = pwdata;
        end
      end
      default: ;
    endcase
  end

  cis_table #(
    .DEPTH (TableDepth),
    .IDX_W (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (s_chan[IdxW-1:0]),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_first_i (dp_q.first),
    .wr_idx_i   (dp_q.chan[IdxW-1:0]),
    .wr_entry_i (wr_entry)
  );

  cis_alu u_alu (
    .sub_a_i  (alu_a),
    .sub_b_i  (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow),
    .zero_o   (alu_zero),
    .mul_a_i  (mul_a),
    .mul_b_i  (tps_q),
    .prod_o   (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = s_in_range ? S_GAP : S_OUT;
      S_GAP:    state_d = S_MIN;
      S_MIN:    state_d = S_MAX;
      S_MAX:    state_d = S_SPAN;
      S_SPAN:   state_d = (n_multi && !alu_borrow && !alu_zero) ? S_MUL_LO : S_OUT;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_ACC;
      S_ACC:    state_d = S_OVF;
      S_OVF:    state_d = alu_borrow ? S_DIV : S_OUT;
      S_DIV:    if (dp_q.step == STEP_W'(DIV_STEPS - 1)) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, table ports, shared unit operands
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    mul_a         = n_minus1[HALF_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = in_acc;
      end
      S_GAP: begin
        alu_a = {1'b0, dp_q.tstamp};
        alu_b = {1'b0, rd_entry.last_time};
      end
      S_MIN: begin
        alu_a = {1'b0, dp_q.gap};
        alu_b = {1'b0, rd_entry.min_gap};
      end
      S_MAX: begin
        alu_a = {1'b0, rd_entry.max_gap};
        alu_b = {1'b0, dp_q.gap};
      end
      S_SPAN: begin
        alu_a = {1'b0, dp_q.tstamp};
        alu_b = {1'b0, (dp_q.first ? dp_q.tstamp : rd_entry.first_time)};
        wr_en = 1'b1;
      end
      S_MUL_LO: mul_a = n_minus1[HALF_W-1:0];
      S_MUL_HI: mul_a = {16'b0, n_minus1[COUNT_W-1:HALF_W]};
      S_ACC: ;
      S_OVF: begin
        alu_a = dp_q.rem;
        alu_b = {1'b0, dp_q.span};
      end
      S_DIV: begin
        alu_a = rem_sh;
        alu_b = {1'b0, dp_q.span};
      end
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  assign wr_entry = '{
    count:      dp_q.n,
    first_time: dp_q.tstamp,
    last_time:  dp_q.tstamp,
    min_gap:    dp_q.min_gap,
    max_gap:    dp_q.max_gap
  };

  // datapath
  always_comb begin
    dp_d    = dp_q;
    total_d = total_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dp_d.chan     = s_chan;
          dp_d.tstamp   = s_time;
          dp_d.in_range = s_in_range;
        end
      end
      S_GAP: begin
        dp_d.gap   = alu_diff[TIME_W-1:0];
        dp_d.back  = alu_borrow;
        dp_d.first = (rd_entry.count == '0);
        dp_d.n     = cnt_sat ? rd_entry.count : rd_entry.count + COUNT_W'(1);
        if (!cnt_sat && total_q != TOTAL_MAX) begin
          total_d = total_q + TOTAL_W'(1);
        end
      end
      S_MIN: dp_d.min_gap = (gap_ok && alu_borrow) ? dp_q.gap : rd_entry.min_gap;
      S_MAX: dp_d.max_gap = (gap_ok && alu_borrow) ? dp_q.gap : rd_entry.max_gap;
      S_SPAN: begin
        dp_d.span = alu_diff[TIME_W-1:0];
        dp_d.rate = '0;
      end
      S_MUL_LO: dp_d.prod_lo = mul_prod;
      S_MUL_HI: dp_d.prod_hi = mul_prod[COUNT_W-1:0];
      S_ACC: begin
        // dividend = product << 16, top 32 bits start the remainder
        dp_d.rem = {32'b0, acc_top[COUNT_W-1:FRAC_W]};
        dp_d.quo = {acc_top[FRAC_W-1:0], dp_q.prod_lo[HALF_W-1:0], 16'b0};
      end
      S_OVF: begin
        // quotient reaches 2^64 exactly when the top 32 bits are not below span
        if (!alu_borrow) begin
          dp_d.rate = '1;
        end
        dp_d.step = '0;
      end
      S_DIV: begin
        dp_d.rem  = alu_borrow ? rem_sh : alu_diff;
        dp_d.quo  = {dp_q.quo[WORD_W-2:0], !alu_borrow};
        dp_d.rate = {dp_q.quo[WORD_W-2:0], !alu_borrow};
        dp_d.step = dp_q.step + STEP_W'(1);
      end
      S_OUT:   ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      if (dp_q.in_range) begin
        out_data_d = {{OUT_PAD_W{1'b0}}, total_q, dp_q.rate, dp_q.max_gap, min_out, dp_q.n};
      end else begin
        out_data_d = {{OUT_PAD_W{1'b0}}, total_q,
                      {(OUT_DATA_W - OUT_PAD_W - TOTAL_W){1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      tps_q       <= TPS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      tps_q       <= tps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q       <= dp_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_div_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dp_q.span != '0)
    else $error("divide started with zero span");

  a_div_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dp_q.rem < {1'b0, dp_q.span})
    else $error("divider remainder not below span");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> dp_q.in_range)
    else $error("table written for out-of-range channel");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("new word taken while previous one still in work");
`endif

endmodule

/* design/cis_table.sv */
// ----------------------------------------------------------------------------
// cis_table: per-channel statistics table
// Count, gap and time tables indexed by channel, one registered read port and
// one write port. Count and gap entries reset; time entries hold until written.
// ----------------------------------------------------------------------------
module cis_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output cis_pkg::entry_t  rd_entry_o,
  input  logic             wr_en_i,
  input  logic             wr_first_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  cis_pkg::entry_t  wr_entry_i
);
  import cis_pkg::*;

  logic [COUNT_W-1:0] count_q [DEPTH];
  logic [TIME_W-1:0]  min_q   [DEPTH];
  logic [TIME_W-1:0]  max_q   [DEPTH];
  logic [TIME_W-1:0]  first_q [DEPTH];
  logic [TIME_W-1:0]  last_q  [DEPTH];
  entry_t             rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        count_q[i] <= '0;
        min_q[i]   <= '1;
        max_q[i]   <= '0;
      end
    end else if (wr_en_i) begin
      count_q[wr_idx_i] <= wr_entry_i.count;
      min_q[wr_idx_i]   <= wr_entry_i.min_gap;
      max_q[wr_idx_i]   <= wr_entry_i.max_gap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      last_q[wr_idx_i] <= wr_entry_i.last_time;
      if (wr_first_i) begin
        first_q[wr_idx_i] <= wr_entry_i.first_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.count      <= count_q[rd_idx_i];
      rd_q.first_time <= first_q[rd_idx_i];
      rd_q.last_time  <= last_q[rd_idx_i];
      rd_q.min_gap    <= min_q[rd_idx_i];
      rd_q.max_gap    <= max_q[rd_idx_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

/* design/cis_alu.sv */
// ----------------------------------------------------------------------------
// cis_alu: shared arithmetic unit
// One 64-bit subtractor with borrow, used for gaps, compares, span and the
// restoring divide, plus one 32x32 multiplier for the rate product.
// ----------------------------------------------------------------------------
module cis_alu (
  input  logic [cis_pkg::WORD_W-1:0] sub_a_i,
  input  logic [cis_pkg::WORD_W-1:0] sub_b_i,
  output logic [cis_pkg::WORD_W-1:0] diff_o,
  output logic                       borrow_o,
  output logic                       zero_o,
  input  logic [cis_pkg::HALF_W-1:0] mul_a_i,
  input  logic [cis_pkg::HALF_W-1:0] mul_b_i,
  output logic [cis_pkg::WORD_W-1:0] prod_o
);
  import cis_pkg::*;

  logic [WORD_W:0] full;

  // borrow set means a < b
  assign full     = {1'b0, sub_a_i} - {1'b0, sub_b_i};
  assign diff_o   = full[WORD_W-1:0];
  assign borrow_o = full[WORD_W];
  assign zero_o   = (full[WORD_W-1:0] == '0);
  assign prod_o   = WORD_W'(mul_a_i) * WORD_W'(mul_b_i);

endmodule
